/* design/assert_macros.svh */
// assertion macros used by the strobe knob controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SRDK_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srdk assertion failed");

// next-cycle implication, checked out of reset
`define SRDK_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srdk assertion failed");

`endif

/* design/srdk_pkg.sv */
// shared types, widths and constants of the strobe knob control unit
package srdk_pkg;

  // default parameter values
  localparam int PERIOD_WIDTH_DEF  = 16;
  localparam int MAX_DENOM_EXP_DEF = 6;

  // field widths
  localparam int REQ_W      = 2;
  localparam int PHASE_W    = 2;
  localparam int FINE_W     = 7;
  localparam int COARSE_W   = 10;
  localparam int FREQ_W     = 14;
  localparam int AGE_W      = 8;
  localparam int CLK_W      = 24;
  localparam int DUTY_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // bit-serial divider length, one quotient bit per step
  localparam int DIV_BITS  = CLK_W;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);

  // reset values
  localparam int RESET_FINE   = 1;
  localparam int RESET_COARSE = 50;
  localparam int RESET_MIN    = 20;
  localparam int RESET_MAX    = 10000;
  localparam int RESET_WINDOW = 190;
  localparam int RESET_CAP    = 200;
  localparam int RESET_TCLK   = 1250000;
  localparam int RESET_FREQ   = 20;
  localparam int RESET_EXP    = 4;
  localparam int RESET_AGE    = 200;

  // event codes
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_KNOB  = 2'd1,
    REQ_CLICK = 2'd2
  } req_t;

  // knob second phase codes
  typedef enum logic [PHASE_W-1:0] {
    PHASE_UP       = 2'd0,
    PHASE_UNSTABLE = 2'd1,
    PHASE_DOWN     = 2'd2
  } phase_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FINE_STEP    = 3'd0,
    CFG_COARSE_STEP  = 3'd1,
    CFG_MIN_FREQ     = 3'd2,
    CFG_MAX_FREQ     = 3'd3,
    CFG_CLICK_WINDOW = 3'd4,
    CFG_TICK_CAP     = 3'd5,
    CFG_TIMER_CLOCK  = 3'd6
  } cfg_index_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;      // input transaction, apply the event to the state
    logic div_load;  // load the divider with clock and frequency
    logic div_step;  // one restoring division step
    logic out_load;  // load the result register
  } srdk_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // result register empty or being taken this cycle
  } srdk_status_t;

endpackage

/* design/srdk_ifs.sv */
// handshake channel interfaces: event input, result output, configuration write

interface srdk_in_if;
  logic                        valid;
  logic                        ready;
  logic [srdk_pkg::REQ_W-1:0]   req_type;
  logic [srdk_pkg::PHASE_W-1:0] phase_b_level;
  logic                        button_held;

  modport source (output valid, req_type, phase_b_level, button_held, input ready);
  modport sink   (input valid, req_type, phase_b_level, button_held, output ready);
endinterface

interface srdk_out_if #(
  parameter int PERIOD_WIDTH = srdk_pkg::PERIOD_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic [PERIOD_WIDTH-1:0]     period_count;
  logic [PERIOD_WIDTH-1:0]     compare_count;
  logic                        edit_mode;
  logic [srdk_pkg::FREQ_W-1:0] freq_tenths_out;
  logic [srdk_pkg::DUTY_W-1:0] duty_denominator;

  modport source (output valid, period_count, compare_count, edit_mode, freq_tenths_out,
                  duty_denominator, input ready);
  modport sink   (input valid, period_count, compare_count, edit_mode, freq_tenths_out,
                  duty_denominator, output ready);
endinterface

interface srdk_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [srdk_pkg::CFG_IDX_W-1:0]  index;
  logic [srdk_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/srdk_ctrl.sv */
// controller: sequences event update, bit-serial division and result load
`include "assert_macros.svh"

module srdk_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  srdk_pkg::srdk_status_t status,
  output srdk_pkg::srdk_cmd_t    cmd
);
  import srdk_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_WRITE
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 div_last;

  assign div_last = (cnt == DIV_CNT_W'(DIV_BITS - 1));

  // commands decoded from the state
  assign in_ready     = (state == ST_IDLE);
  assign cmd.take     = in_valid && in_ready;
  assign cmd.div_load = (state == ST_LOAD);
  assign cmd.div_step = (state == ST_DIV);
  assign cmd.out_load = (state == ST_WRITE) && status.out_free;

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.take) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (div_last) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // sequencing checks
  `SRDK_ASSERT_NXT(a_take_to_load, clk, rst, cmd.take, state == ST_LOAD && !in_ready)
  `SRDK_ASSERT_NXT(a_load_to_div, clk, rst, state == ST_LOAD, state == ST_DIV && cnt == '0)
  `SRDK_ASSERT_NXT(a_div_to_write, clk, rst, state == ST_DIV && div_last, state == ST_WRITE)

endmodule

/* design/srdk_datapath.sv */
// datapath: config registers, knob state, serial divider and result register
module srdk_datapath #(
  parameter int PERIOD_WIDTH  = srdk_pkg::PERIOD_WIDTH_DEF,
  parameter int MAX_DENOM_EXP = srdk_pkg::MAX_DENOM_EXP_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write
  input  logic                            cfg_we,
  input  logic [srdk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srdk_pkg::CFG_DATA_W-1:0] cfg_data,
  // event payload
  input  logic [srdk_pkg::REQ_W-1:0]      req_type,
  input  logic [srdk_pkg::PHASE_W-1:0]    phase_b_level,
  input  logic                            button_held,
  // control
  input  srdk_pkg::srdk_cmd_t             cmd,
  output srdk_pkg::srdk_status_t          status,
  // result
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [PERIOD_WIDTH-1:0]         period_count,
  output logic [PERIOD_WIDTH-1:0]         compare_count,
  output logic                            edit_mode,
  output logic [srdk_pkg::FREQ_W-1:0]     freq_tenths_out,
  output logic [srdk_pkg::DUTY_W-1:0]     duty_denominator
);
  import srdk_pkg::*;

  localparam int EXP_BITS = $clog2(MAX_DENOM_EXP + 1);
  localparam int EW       = (EXP_BITS > 3) ? EXP_BITS : 3;
  localparam int SUM_W    = FREQ_W + 1;

  // configuration registers
  logic [FINE_W-1:0]   fine_step;
  logic [COARSE_W-1:0] coarse_step;
  logic [FREQ_W-1:0]   min_freq;
  logic [FREQ_W-1:0]   max_freq;
  logic [AGE_W-1:0]    click_window;
  logic [AGE_W-1:0]    tick_cap;
  logic [CLK_W-1:0]    timer_clock_tenths;

  // knob state
  logic [FREQ_W-1:0] frequency_reg, frequency_reg_next;
  logic [EW-1:0]     denominator_exponent, denominator_exponent_next;
  logic              mode_reg, mode_reg_next;
  logic [AGE_W-1:0]  click_age, click_age_next;

  // divider
  logic [FREQ_W-1:0] div_rem, div_rem_next;
  logic [CLK_W-1:0]  div_quo;
  logic [FREQ_W-1:0] div_den;
  logic              div_zero;
  logic [SUM_W-1:0]  trial;
  logic              trial_ge;

  // result path
  logic [SUM_W-1:0]        step_w;
  logic [SUM_W-1:0]        up_sum;
  logic [SUM_W-1:0]        down_limit;
  logic                    sat;
  logic [PERIOD_WIDTH-1:0] period;
  logic [PERIOD_WIDTH-1:0] compare;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fine_step          <= FINE_W'(RESET_FINE);
      coarse_step        <= COARSE_W'(RESET_COARSE);
      min_freq           <= FREQ_W'(RESET_MIN);
      max_freq           <= FREQ_W'(RESET_MAX);
      click_window       <= AGE_W'(RESET_WINDOW);
      tick_cap           <= AGE_W'(RESET_CAP);
      timer_clock_tenths <= CLK_W'(RESET_TCLK);
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_FINE_STEP:    fine_step          <= cfg_data[FINE_W-1:0];
        CFG_COARSE_STEP:  coarse_step        <= cfg_data[COARSE_W-1:0];
        CFG_MIN_FREQ:     min_freq           <= cfg_data[FREQ_W-1:0];
        CFG_MAX_FREQ:     max_freq           <= cfg_data[FREQ_W-1:0];
        CFG_CLICK_WINDOW: click_window       <= cfg_data[AGE_W-1:0];
        CFG_TICK_CAP:     tick_cap           <= cfg_data[AGE_W-1:0];
        CFG_TIMER_CLOCK:  timer_clock_tenths <= cfg_data[CLK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // frequency step sums, strict limits
  assign step_w     = button_held ? SUM_W'(coarse_step) : SUM_W'(fine_step);
  assign up_sum     = SUM_W'(frequency_reg) + step_w;
  assign down_limit = SUM_W'(min_freq) + step_w;

  // event update
  always_comb begin
    frequency_reg_next        = frequency_reg;
    denominator_exponent_next = denominator_exponent;
    mode_reg_next             = mode_reg;
    click_age_next            = click_age;
    case (req_t'(req_type))
      REQ_TICK: begin
        if (click_age < tick_cap) begin
          click_age_next = click_age + 1'b1;
        end
      end
      REQ_KNOB: begin
        if (!mode_reg) begin
          if (phase_b_level == PHASE_UP && up_sum < SUM_W'(max_freq)) begin
            frequency_reg_next = up_sum[FREQ_W-1:0];
          end else if (phase_b_level == PHASE_DOWN && SUM_W'(frequency_reg) > down_limit) begin
            frequency_reg_next = FREQ_W'(SUM_W'(frequency_reg) - step_w);
          end
        end else begin
          if (phase_b_level == PHASE_UP && denominator_exponent < EW'(MAX_DENOM_EXP)) begin
            denominator_exponent_next = denominator_exponent + 1'b1;
          end else if (phase_b_level == PHASE_DOWN && denominator_exponent > EW'(1)) begin
            denominator_exponent_next = denominator_exponent - 1'b1;
          end
        end
      end
      REQ_CLICK: begin
        if (click_age < click_window) begin
          mode_reg_next = !mode_reg;
        end
        click_age_next = '0;
      end
      default: begin
      end
    endcase
  end

  // knob state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frequency_reg        <= FREQ_W'(RESET_FREQ);
      denominator_exponent <= EW'(RESET_EXP);
      mode_reg             <= 1'b0;
      click_age            <= AGE_W'(RESET_AGE);
    end else if (cmd.take) begin
      frequency_reg        <= frequency_reg_next;
      denominator_exponent <= denominator_exponent_next;
      mode_reg             <= mode_reg_next;
      click_age            <= click_age_next;
    end
  end

  // restoring division step, one quotient bit per cycle
  assign trial        = {div_rem, div_quo[CLK_W-1]};
  assign trial_ge     = (trial >= SUM_W'(div_den));
  assign div_rem_next = trial_ge ? FREQ_W'(trial - SUM_W'(div_den)) : trial[FREQ_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_rem  <= '0;
      div_quo  <= timer_clock_tenths;
      div_den  <= frequency_reg;
      div_zero <= (frequency_reg == '0);
    end else if (cmd.div_step) begin
      div_rem  <= div_rem_next;
      div_quo  <= {div_quo[CLK_W-2:0], trial_ge};
    end
  end

  // saturate period, compare is period minus period over denominator
  assign sat     = div_zero || (|(div_quo >> PERIOD_WIDTH));
  assign period  = sat ? '1 : PERIOD_WIDTH'(div_quo);
  assign compare = period - (period >> denominator_exponent);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      period_count     <= period;
      compare_count    <= compare;
      edit_mode        <= mode_reg;
      freq_tenths_out  <= frequency_reg;
      duty_denominator <= DUTY_W'(1) << denominator_exponent;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

/* design/strobe_rate_duty_knob_control_unit.sv */
// strobe knob control top level: one result per event, period by 24-step serial divide
// sequence: event update on the input transaction, divider load, 24 divide steps, result load
// a new event is accepted only when idle, after the result load that waits for a free result register
// the result register lets the next event enter while a result waits to be taken
// reset: synchronous, clears config to defaults, frequency 20, denominator 16, age 200
module strobe_rate_duty_knob_control_unit #(
  parameter int PERIOD_WIDTH  = srdk_pkg::PERIOD_WIDTH_DEF,
  parameter int MAX_DENOM_EXP = srdk_pkg::MAX_DENOM_EXP_DEF
) (
  input logic         clk,
  input logic         rst,
  srdk_in_if.sink     in_ch,
  srdk_out_if.source  out_ch,
  srdk_cfg_if.sink    cfg
);
  import srdk_pkg::*;

  srdk_cmd_t    cmd;
  srdk_status_t status;

  // configuration is always taken
  assign cfg.ready = 1'b1;

  // controller
  srdk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  srdk_datapath #(
    .PERIOD_WIDTH  (PERIOD_WIDTH),
    .MAX_DENOM_EXP (MAX_DENOM_EXP)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg.valid && cfg.ready),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .req_type         (in_ch.req_type),
    .phase_b_level    (in_ch.phase_b_level),
    .button_held      (in_ch.button_held),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .period_count     (out_ch.period_count),
    .compare_count    (out_ch.compare_count),
    .edit_mode        (out_ch.edit_mode),
    .freq_tenths_out  (out_ch.freq_tenths_out),
    .duty_denominator (out_ch.duty_denominator)
  );

endmodule
